>>> sv/stbs_pkg.sv
// Shared types and constants for the sorted table binary search block.
// Used by stbs_ctrl, stbs_datapath and sorted_table_binary_search; no dependencies.
`default_nettype none

package stbs_pkg;

  localparam int SLOT_BITS  = 10;
  localparam int KEY_BITS   = 32;
  localparam int PROBE_BITS = 4;

  localparam logic [PROBE_BITS-1:0] PROBE_MAX = '1;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic                       op;
    logic [SLOT_BITS-1:0]       slot;
    logic signed [KEY_BITS-1:0] entry_value;
    logic signed [KEY_BITS-1:0] key;
    logic [SLOT_BITS-1:0]       lo_slot;
    logic [SLOT_BITS-1:0]       hi_slot;
  } req_word_t;

  typedef struct packed {
    logic                  found;
    logic [SLOT_BITS-1:0]  found_slot;
    logic [PROBE_BITS-1:0] probes;
  } rsp_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic wr_en;
    logic rd_en;
    logic step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic equal;
  } sts_t;

endpackage

`default_nettype wire

>>> sv/stbs_datapath.sv
// Datapath of the binary search block: table memory, search bounds, probe counter
// and result register. Depends on stbs_pkg.
`default_nettype none

module stbs_datapath #(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic              clk,
  input  wire stbs_pkg::req_word_t req,
  input  wire stbs_pkg::cmd_t    cmd,
  output stbs_pkg::sts_t         sts,
  output stbs_pkg::rsp_word_t    rsp
);

  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W     = ((ADDR_BITS > stbs_pkg::SLOT_BITS) ? ADDR_BITS
                                                                : stbs_pkg::SLOT_BITS) + 2;

  logic signed [VALUE_BITS-1:0] mem [DEPTH];

  logic signed [IDX_W-1:0]      lo;
  logic signed [IDX_W-1:0]      hi;
  logic [IDX_W-1:0]             mid;
  logic [IDX_W-1:0]             mid_q;
  logic signed [VALUE_BITS-1:0] key_q;
  logic signed [VALUE_BITS-1:0] rdata;
  logic [stbs_pkg::PROBE_BITS-1:0] count;
  logic                         found;

  logic signed [63:0]           wval_ext;
  logic signed [63:0]           key_ext;
  logic [IDX_W-1:0]             wslot;
  logic [IDX_W-1:0]             hi_in;
  logic [IDX_W-1:0]             sum;

  // Values are sign-extended from 32 bits, then cut to the table width.
  assign wval_ext = 64'(req.entry_value);
  assign key_ext  = 64'(req.key);
  assign wslot    = IDX_W'(req.slot);
  assign hi_in    = (IDX_W'(req.hi_slot) > IDX_W'(DEPTH - 1)) ? IDX_W'(DEPTH - 1)
                                                               : IDX_W'(req.hi_slot);
  assign sum      = lo + hi;
  assign mid      = sum >> 1;

  assign sts.empty = (lo > hi);
  assign sts.equal = (rdata == key_q);

  always_ff @(posedge clk) begin
    if (cmd.wr_en && (wslot < IDX_W'(DEPTH))) begin
      mem[wslot[ADDR_BITS-1:0]] <= wval_ext[VALUE_BITS-1:0];
    end
    if (cmd.rd_en) begin
      rdata <= mem[mid[ADDR_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo    <= $signed(IDX_W'(req.lo_slot));
      hi    <= $signed(hi_in);
      key_q <= key_ext[VALUE_BITS-1:0];
      count <= '0;
      found <= 1'b0;
    end
    if (cmd.rd_en) begin
      mid_q <= mid;
    end
    if (cmd.step) begin
      if (count != stbs_pkg::PROBE_MAX) begin
        count <= count + 1'b1;
      end
      if (rdata == key_q) begin
        found <= 1'b1;
      end else if (key_q < rdata) begin
        hi <= $signed(mid_q - 1'b1);
      end else begin
        lo <= $signed(mid_q + 1'b1);
      end
    end
    if (cmd.finish) begin
      rsp.found      <= found;
      rsp.found_slot <= found ? mid_q[stbs_pkg::SLOT_BITS-1:0] : '0;
      rsp.probes     <= count;
    end
  end

endmodule

`default_nettype wire

>>> sv/stbs_ctrl.sv
// Controller state machine of the binary search block.
// Drives datapath commands and both handshakes. Depends on stbs_pkg.
`default_nettype none

module stbs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  input  wire logic           req_op,
  output logic                req_stall,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  input  wire stbs_pkg::sts_t sts,
  output stbs_pkg::cmd_t      cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       rsp_free;

  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req_op == stbs_pkg::OP_SEARCH) begin
            cmd.load   = 1'b1;
            state_next = S_CHECK;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (sts.empty) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.step   = 1'b1;
        state_next = sts.equal ? S_DONE : S_CHECK;
      end
      S_DONE: begin
        if (rsp_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= cmd.finish || (rsp_valid && rsp_stall);
    end
  end

endmodule

`default_nettype wire

>>> sv/sorted_table_binary_search.sv
// Binary search over a sorted table of signed entries. A write word gives no result
// and leaves the block ready for the next word. A search word keeps the input stalled
// until its result is registered: one probe is a registered table read plus a compare.
// At DEPTH 1024 a search takes at most 11 probes.
// Reset clears the controller and the result valid flag; table contents stay undefined
// until written, and there is no clearing pass. Depends on stbs_pkg, stbs_ctrl, stbs_datapath.
`default_nettype none

module sorted_table_binary_search #(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire stbs_pkg::req_word_t  req,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output stbs_pkg::rsp_word_t       rsp
);

  // Largest number of probes any search can make, capped by the probe counter.
  localparam int PROBE_LIMIT_RAW = $clog2(DEPTH) + 1;
  localparam int PROBE_LIMIT     = (PROBE_LIMIT_RAW > 15) ? 15 : PROBE_LIMIT_RAW;

  stbs_pkg::cmd_t cmd;
  stbs_pkg::sts_t sts;

  // The controller walks each search through check and compare steps. It takes no
  // new word while a search is in flight, but the result register lets it accept
  // the next word while an earlier result still waits downstream.
  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_op    (req.op),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the table memory, the narrowing bounds and the result word.
  stbs_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk (clk),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

  // A hit always comes from at least one probe.
  a_found_has_probe: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!rsp.found || (rsp.probes != '0)))
    else $error("found result with zero probes");

  // A miss reports slot zero.
  a_miss_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.found) |-> (rsp.found_slot == '0))
    else $error("miss reports nonzero slot");

  // A binary search never exceeds its probe bound.
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.probes <= stbs_pkg::PROBE_BITS'(PROBE_LIMIT)))
    else $error("probe count above search bound");

  // An accepted search keeps the input stalled in the next cycle.
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && (req.op == stbs_pkg::OP_SEARCH)) |=> req_stall)
    else $error("input not stalled during search");

endmodule

`default_nettype wire

>>> bench/search_checker.sv
`timescale 1ns / 100ps
// search_checker: watches both channels of sorted_table_binary_search, keeps its own
// copy of the table, predicts every search answer and compares. Depends on stbs_pkg.
module search_checker
  import stbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_stall,
  input  req_word_t req,
  input  logic      rsp_valid,
  input  logic      rsp_stall,
  input  rsp_word_t rsp,
  output int        fail_count,
  output int        waiting
);

  localparam int SLOTS = 1 << SLOT_BITS;

  logic signed [KEY_BITS-1:0] table_copy [SLOTS];
  rsp_word_t                  expected_answers [$];
  rsp_word_t                  want;

  initial begin
    fail_count = 0;
    waiting    = 0;
  end

  // Walk the search the way the block does, over the table as it stands now.
  function automatic rsp_word_t search_table(logic signed [KEY_BITS-1:0] key,
                                             logic [SLOT_BITS-1:0] lo_slot,
                                             logic [SLOT_BITS-1:0] hi_slot);
    int        lo;
    int        hi;
    int        mid;
    int        count;
    rsp_word_t answer;
    answer = '0;
    count  = 0;
    lo     = lo_slot;
    hi     = hi_slot;
    if (hi > SLOTS - 1) hi = SLOTS - 1;
    while (lo <= hi) begin
      mid   = (lo + hi) / 2;
      count = count + 1;
      if (table_copy[mid] == key) begin
        answer.found      = 1'b1;
        answer.found_slot = mid[SLOT_BITS-1:0];
        break;
      end else if (key < table_copy[mid]) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    answer.probes = (count > PROBE_MAX) ? PROBE_MAX : count[PROBE_BITS-1:0];
    return answer;
  endfunction

  task automatic flag_field(string field, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      fail_count = fail_count + 1;
      $display("%0t: %s expected %0d, got %0d", $time, field, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid === 1'b1 && req_stall === 1'b0) begin
        if (req.op == OP_WRITE)
          table_copy[req.slot] = req.entry_value;
        else
          expected_answers.push_back(search_table(req.key, req.lo_slot, req.hi_slot));
      end
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
        if (expected_answers.size() == 0) begin
          fail_count = fail_count + 1;
          $display("%0t: result expected none, got found=%0d slot=%0d probes=%0d",
                   $time, rsp.found, rsp.found_slot, rsp.probes);
        end else begin
          want = expected_answers.pop_front();
          flag_field("found", want.found, rsp.found);
          flag_field("found_slot", want.found_slot, rsp.found_slot);
          flag_field("probes", want.probes, rsp.probes);
        end
      end
      waiting <= expected_answers.size();
    end
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// tb_top: clock, reset and stimulus for sorted_table_binary_search, plus the verdict.
// Depends on stbs_pkg, sorted_table_binary_search and search_checker.
module tb_top;
  import stbs_pkg::*;

  localparam int SLOTS        = 1 << SLOT_BITS;
  localparam int VAL_MIN      = -2147483647 - 1;
  localparam int VAL_MAX      = 2147483647;
  localparam int RANDOM_WORDS = 680;
  localparam int LONG_HOLD    = 600;
  // Clocks to run on after the last answer has come back, before the verdict.
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 1_500_000;

  logic      clk = 1'b0;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  req_word_t req;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_word_t rsp;
  int        fail_count;
  int        waiting;

  // The sender raises calm for stretches in which neither side idles.
  logic calm;
  // The stimulus raises hold_kick once; the receiver then starts its long hold-off, counted down from LONG_HOLD.
  logic hold_kick;
  logic hold_spent = 1'b0;
  int   stall_left = 0;
  int   stall_len;
  int   cycles = 0;

  // Values last written per slot, kept so that searches can aim at keys that are present.
  int stock [SLOTS];

  always #5 clk = ~clk;

  sorted_table_binary_search DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  search_checker search_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .waiting    (waiting)
  );

  // Idle lengths: mostly none; otherwise drawn from one of three ranges, each rarer and longer than the last.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Uniform value in [lo_v, hi_v]; the caller makes sure lo_v <= hi_v.
  function automatic int between(longint lo_v, longint hi_v);
    longint unsigned span;
    span = hi_v - lo_v + 1;
    return int'(lo_v + longint'({$urandom, $urandom} % span));
  endfunction

  // A word with every field random; the ignored fields of each operation keep that noise.
  function automatic req_word_t raw_word();
    logic [95:0] noise;
    noise = {$urandom, $urandom, $urandom};
    return noise[$bits(req_word_t)-1:0];
  endfunction

  // Receiver: random stalls, none in calm stretches, and one long hold-off on request.
  // The long hold keeps the result word waiting, so the block soon stalls its input
  // while the sender keeps offering words.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
    if (hold_kick && !hold_spent) begin
      hold_spent <= 1'b1;
      rsp_stall  <= 1'b1;
      stall_left <= LONG_HOLD;
    end else if (stall_left != 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      stall_len = calm ? 0 : pick_gap();
      rsp_stall  <= (stall_len != 0);
      stall_left <= (stall_len > 1) ? stall_len - 1 : 0;
    end
  end

  // Offer one word and return at the edge where it is taken. Valid stays high on return,
  // so back-to-back words never lower and raise it within one time step.
  task automatic send_word(input req_word_t w);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic put_entry(input int s, input int v);
    req_word_t w;
    w             = raw_word();
    w.op          = OP_WRITE;
    w.slot        = s[SLOT_BITS-1:0];
    w.entry_value = v;
    stock[s]      = v;
    send_word(w);
  endtask

  task automatic ask(input int k, input int lo, input int hi);
    req_word_t w;
    w         = raw_word();
    w.op      = OP_SEARCH;
    w.key     = k;
    w.lo_slot = lo[SLOT_BITS-1:0];
    w.hi_slot = hi[SLOT_BITS-1:0];
    send_word(w);
  endtask

  // Stop offering until every search answer that is owed has come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  // Fill the whole table in ascending order from the most negative value to the most
  // positive, with an occasional repeated value.
  task automatic fill_sorted();
    longint v;
    v = VAL_MIN;
    for (int s = 0; s < SLOTS; s++) begin
      if (s == SLOTS - 1)
        v = VAL_MAX;
      else if (s != 0 && $urandom_range(0, 15) != 0)
        v = v + $urandom_range(1, 1 << 22);
      if (v > VAL_MAX) v = VAL_MAX;
      put_entry(s, int'(v));
    end
  endtask

  // Search over a full, a random, a short or an empty range. The key is most often one
  // that sits in the range, else a near miss, a random value, an extreme, zero or -1.
  task automatic random_search();
    int lo;
    int hi;
    int pick;
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        lo = 0;
        hi = SLOTS - 1;
      end
      3, 4, 5, 6: begin
        lo = $urandom_range(0, SLOTS - 1);
        hi = $urandom_range(lo, SLOTS - 1);
      end
      7, 8: begin
        lo = $urandom_range(0, SLOTS - 1);
        hi = lo + $urandom_range(0, 7);
        if (hi > SLOTS - 1) hi = SLOTS - 1;
      end
      default: begin
        hi = $urandom_range(0, SLOTS - 2);
        lo = $urandom_range(hi + 1, SLOTS - 1);
      end
    endcase
    pick = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(0, SLOTS - 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: k = stock[pick];
      5:             k = stock[pick] + 1;
      6:             k = stock[pick] - 1;
      7, 8:          k = $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0:       k = VAL_MIN;
          1:       k = VAL_MAX;
          2:       k = 0;
          default: k = -1;
        endcase
      end
    endcase
    ask(k, lo, hi);
  endtask

  // Rewrite one slot with a value that keeps the table in order.
  task automatic nudge_entry();
    int     s;
    longint below;
    longint above;
    s     = $urandom_range(0, SLOTS - 1);
    below = (s == 0) ? VAL_MIN : stock[s-1];
    above = (s == SLOTS - 1) ? VAL_MAX : stock[s+1];
    put_entry(s, (below <= above) ? between(below, above) : int'(below));
  endtask

  // Rewrite a short run of slots with a fresh ascending sequence between its neighbors.
  task automatic refill_run();
    int     first;
    int     last;
    int     v;
    longint above;
    first = $urandom_range(0, SLOTS - 1);
    last  = first + $urandom_range(1, 9);
    if (last > SLOTS - 1) last = SLOTS - 1;
    v     = (first == 0) ? VAL_MIN : stock[first-1];
    above = (last == SLOTS - 1) ? VAL_MAX : stock[last+1];
    if (above < v) above = v;
    for (int s = first; s <= last; s++) begin
      v = between(v, v + (above - v) / (last - s + 1));
      put_entry(s, v);
    end
  endtask

  initial begin : stimulus
    int r;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    calm      <= 1'b0;
    hold_kick <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed words. Searches here only cover slots already written, since the table
    // holds nothing defined until it is written.
    ask(5, SLOTS - 1, 0);                // empty range, widest inversion
    put_entry(0, VAL_MIN);
    put_entry(1, 0);
    put_entry(2, VAL_MAX);
    ask(VAL_MIN, 0, 2);                  // found low, two probes
    ask(VAL_MAX, 0, 2);                  // found high, two probes
    ask(0, 0, 2);                        // found on the first probe
    ask(5, 0, 2);                        // key missing between two entries
    ask(-1, 0, 0);                       // single slot, not found
    ask(VAL_MAX, 2, 2);                  // single slot, found
    put_entry(SLOTS - 2, -1);
    put_entry(SLOTS - 1, VAL_MAX);
    ask(VAL_MAX, SLOTS - 2, SLOTS - 1);  // found in the top slot
    ask(-1, SLOTS - 1, SLOTS - 1);       // top slot alone, not found
    ask(VAL_MIN, SLOTS - 2, SLOTS - 1);  // key below every entry
    ask(-1, SLOTS - 2, SLOTS - 2);
    ask(0, 2, 1);                        // empty range, adjacent bounds
    ask(VAL_MIN, 1, 0);

    // The sender goes quiet until every answer is back, then fills the table.
    wait_drained();
    fill_sorted();

    // Full-range searches take the deepest paths through the table.
    ask(stock[SLOTS-1], 0, SLOTS - 1);
    ask(stock[0], 0, SLOTS - 1);
    ask(stock[SLOTS/3] + 1, 0, SLOTS - 1);

    // Mostly searches and order-keeping rewrites, with a little out-of-order noise.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 64 == 0) calm <= ($urandom_range(0, 3) == 0);
      if (n == RANDOM_WORDS / 4) wait_drained();
      if (n == RANDOM_WORDS / 2) hold_kick <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 70)
        random_search();
      else if (r < 90)
        nudge_entry();
      else if (r < 96)
        refill_run();
      else
        put_entry($urandom_range(0, SLOTS - 1), $urandom);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

>>> sim.f
sv/stbs_pkg.sv
sv/stbs_datapath.sv
sv/stbs_ctrl.sv
sv/sorted_table_binary_search.sv
bench/search_checker.sv
bench/tb_top.sv
